>>> sv/gdq_pkg.sv
// Shared types, constants, glyph table and saturation helper for the glyph dot quad generator.
`default_nettype none

package gdq_pkg;

  // Fixed-point layout of coordinates and scale.
  localparam int FRAC_BITS = 8;
  localparam int COORD_W   = 20;
  localparam int SCALE_W   = 14;
  localparam int HEIGHT_W  = 15;
  localparam int ADV_W     = 17;
  localparam int ACC_W     = 22;
  localparam int COLOR_W   = 32;
  localparam int GLYPH_W   = 35;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(4 << FRAC_BITS);

  // Coordinate limits.
  localparam logic signed [ACC_W-1:0] COORD_MAX = ACC_W'(524287);
  localparam logic signed [ACC_W-1:0] COORD_MIN = -ACC_W'(524288);

  // Divide by ten through a reciprocal: q = (v * DIV10_MUL) >> DIV10_SHIFT.
  localparam logic [20:0] DIV10_MUL   = 21'd1677722;
  localparam int          DIV10_SHIFT = 24;

  // Shadow colors.
  localparam logic [COLOR_W-1:0] SHADOW_COLOR_SD = 32'hA000_0000;
  localparam logic [COLOR_W-1:0] SHADOW_COLOR_HD = 32'hFF00_0000;

  // Configuration register indexes (word address bit 2).
  localparam logic REG_DOT_SCALE = 1'b0;
  localparam logic REG_SD_MODE   = 1'b1;

  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    logic               sd;
  } cfg_t;

  typedef struct packed {
    logic               mode;
    logic               first_of_string;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [7:0]         char_code;
    logic [COLOR_W-1:0] text_color;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0]  quad_x;
    logic [COORD_W-1:0]  quad_y;
    logic [SCALE_W-1:0]  quad_width;
    logic [HEIGHT_W-1:0] quad_height;
    logic [COLOR_W-1:0]  quad_color;
    logic                last_dot;
  } quad_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_BASE_X,
    ST_BASE_Y,
    ST_SCAN,
    ST_ADV
  } state_t;

  // Clamp an exact coordinate to the signed 20-bit field range.
  function automatic logic [COORD_W-1:0] sat20(input logic signed [ACC_W-1:0] v);
    logic [COORD_W-1:0] r;
    if (v > COORD_MAX) begin
      r = COORD_W'(524287);
    end else if (v < COORD_MIN) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  // 5x7 glyph bitmap: row 0 in the top five bits, column 0 is the MSB of each row.
  // Codes without a glyph (space included) give an empty bitmap.
  function automatic logic [GLYPH_W-1:0] glyph_bits(input logic [7:0] code);
    logic [GLYPH_W-1:0] g;
    case (code)
      "A": g = {5'h04, 5'h0A, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11};
      "B": g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
      "C": g = {5'h0F, 5'h18, 5'h10, 5'h10, 5'h10, 5'h18, 5'h0F};
      "D": g = {5'h1E, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1E};
      "E": g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
      "F": g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
      "G": g = {5'h0F, 5'h10, 5'h10, 5'h17, 5'h11, 5'h19, 5'h0F};
      "H": g = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      "I": g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
      "J": g = {5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0C};
      "K": g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
      "L": g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
      "M": g = {5'h11, 5'h1B, 5'h1B, 5'h15, 5'h11, 5'h11, 5'h11};
      "N": g = {5'h11, 5'h19, 5'h19, 5'h15, 5'h13, 5'h13, 5'h11};
      "O": g = {5'h0E, 5'h1B, 5'h11, 5'h11, 5'h11, 5'h1B, 5'h0E};
      "P": g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
      "Q": g = {5'h0E, 5'h1B, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
      "R": g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h18, 5'h14, 5'h13};
      "S": g = {5'h0F, 5'h18, 5'h18, 5'h0E, 5'h03, 5'h03, 5'h1E};
      "T": g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      "U": g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      "V": g = {5'h11, 5'h11, 5'h11, 5'h0A, 5'h0A, 5'h0A, 5'h04};
      "W": g = {5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h1B, 5'h11};
      "X": g = {5'h11, 5'h0A, 5'h0A, 5'h04, 5'h0A, 5'h0A, 5'h11};
      "Y": g = {5'h11, 5'h0A, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
      "Z": g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
      "0": g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
      "1": g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      "2": g = {5'h0E, 5'h11, 5'h01, 5'h06, 5'h08, 5'h10, 5'h1F};
      "3": g = {5'h0E, 5'h11, 5'h01, 5'h06, 5'h01, 5'h11, 5'h0E};
      "4": g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
      "5": g = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
      "6": g = {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      "7": g = {5'h1F, 5'h01, 5'h02, 5'h02, 5'h04, 5'h04, 5'h04};
      "8": g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      "9": g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E};
      ":": g = {5'h00, 5'h06, 5'h06, 5'h00, 5'h06, 5'h06, 5'h00};
      ".": g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h06, 5'h06};
      ",": g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h06, 5'h06, 5'h02};
      ";": g = {5'h00, 5'h06, 5'h06, 5'h00, 5'h06, 5'h06, 5'h02};
      "!": g = {5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04};
      "?": g = {5'h0E, 5'h11, 5'h01, 5'h06, 5'h04, 5'h00, 5'h04};
      "-": g = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
      "_": g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1F};
      "+": g = {5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00};
      "=": g = {5'h00, 5'h1F, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00};
      "/": g = {5'h01, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h10};
      8'h5C: g = {5'h10, 5'h10, 5'h08, 5'h04, 5'h02, 5'h01, 5'h01};
      "(": g = {5'h02, 5'h04, 5'h08, 5'h08, 5'h08, 5'h04, 5'h02};
      ")": g = {5'h08, 5'h04, 5'h02, 5'h02, 5'h02, 5'h04, 5'h08};
      "[": g = {5'h0E, 5'h08, 5'h08, 5'h08, 5'h08, 5'h08, 5'h0E};
      "]": g = {5'h0E, 5'h02, 5'h02, 5'h02, 5'h02, 5'h02, 5'h0E};
      8'h27: g = {5'h04, 5'h04, 5'h04, 5'h00, 5'h00, 5'h00, 5'h00};
      8'h22: g = {5'h0A, 5'h0A, 5'h0A, 5'h00, 5'h00, 5'h00, 5'h00};
      "#": g = {5'h0A, 5'h0A, 5'h1F, 5'h0A, 5'h1F, 5'h0A, 5'h0A};
      "%": g = {5'h18, 5'h19, 5'h02, 5'h04, 5'h08, 5'h13, 5'h03};
      "@": g = {5'h0E, 5'h11, 5'h17, 5'h15, 5'h17, 5'h10, 5'h0E};
      "<": g = {5'h02, 5'h04, 5'h08, 5'h10, 5'h08, 5'h04, 5'h02};
      ">": g = {5'h08, 5'h04, 5'h02, 5'h01, 5'h02, 5'h04, 5'h08};
      "*": g = {5'h00, 5'h15, 5'h0E, 5'h1F, 5'h0E, 5'h15, 5'h00};
      "a": g = {5'h00, 5'h00, 5'h0E, 5'h01, 5'h0F, 5'h11, 5'h0F};
      "b": g = {5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h11, 5'h1E};
      "c": g = {5'h00, 5'h00, 5'h0E, 5'h11, 5'h10, 5'h11, 5'h0E};
      "d": g = {5'h01, 5'h01, 5'h0F, 5'h11, 5'h11, 5'h11, 5'h0F};
      "e": g = {5'h00, 5'h00, 5'h0E, 5'h11, 5'h1F, 5'h10, 5'h0E};
      "f": g = {5'h03, 5'h04, 5'h04, 5'h1E, 5'h04, 5'h04, 5'h04};
      "g": g = {5'h00, 5'h0F, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h0E};
      "h": g = {5'h10, 5'h10, 5'h16, 5'h19, 5'h11, 5'h11, 5'h11};
      "i": g = {5'h00, 5'h04, 5'h00, 5'h0C, 5'h04, 5'h04, 5'h0E};
      "j": g = {5'h00, 5'h02, 5'h00, 5'h06, 5'h02, 5'h12, 5'h0C};
      "k": g = {5'h10, 5'h10, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12};
      "l": g = {5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      "m": g = {5'h00, 5'h00, 5'h1A, 5'h15, 5'h15, 5'h11, 5'h11};
      "n": g = {5'h00, 5'h00, 5'h16, 5'h19, 5'h11, 5'h11, 5'h11};
      "o": g = {5'h00, 5'h00, 5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E};
      "p": g = {5'h00, 5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10};
      "q": g = {5'h00, 5'h0F, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01};
      "r": g = {5'h00, 5'h00, 5'h16, 5'h19, 5'h10, 5'h10, 5'h10};
      "s": g = {5'h00, 5'h00, 5'h0E, 5'h10, 5'h0E, 5'h01, 5'h1E};
      "t": g = {5'h04, 5'h04, 5'h1E, 5'h04, 5'h04, 5'h04, 5'h03};
      "u": g = {5'h00, 5'h00, 5'h11, 5'h11, 5'h11, 5'h13, 5'h0D};
      "v": g = {5'h00, 5'h00, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
      "w": g = {5'h00, 5'h00, 5'h11, 5'h11, 5'h15, 5'h1B, 5'h11};
      "x": g = {5'h00, 5'h00, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11};
      "y": g = {5'h00, 5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h08};
      "z": g = {5'h00, 5'h00, 5'h1F, 5'h02, 5'h04, 5'h08, 5'h1F};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

>>> sv/glyph_dot_quad_generator.sv
// Top level of the 5x7 glyph dot quad generator: stream ports, configuration port, engine.
`default_nettype none

// Takes one character per item and emits one rectangle item for each set dot of its
// 5x7 glyph, rows top to bottom and columns left to right, with tlast on the final dot.
// The block takes one character at a time and is not ready while it works on it. An item
// goes through setup (accept, reciprocal multiply for the shadow offset, x and y base
// sums), then one scan step per glyph position up to and including the last set dot (at
// most 35), then the cursor advance; an empty glyph skips the scan. A step that emits a dot
// waits while the output holds an untaken quad. The pace is set by the single shared adder
// that steps the dot position once per scanned position. Configuration (dot_scale at 0x0,
// sd_mode at 0x4) is to be written only while the block is idle; the block does not enforce it.
module glyph_dot_quad_generator (
  input  wire logic         clk,
  input  wire logic         rst,
  // Input item stream.
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [79:0]  s_tdata,   // start_x[19:0], start_y[39:20], char_code[47:40],
                                       // text_color[79:48]
  input  wire logic [1:0]   s_tuser,   // mode[0], first_of_string[1]
  // Result item stream.
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [103:0]      m_tdata,   // quad_x[19:0], quad_y[39:20], quad_width[53:40],
                                       // quad_height[68:54], quad_color[100:69], zero[103:101]
  output logic              m_tlast,   // last_dot
  // Configuration port.
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import gdq_pkg::*;

  cfg_t     cfg;
  in_item_t in_item;
  quad_t    out_quad;

  gdq_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Unpack the input item.
  always_comb begin
    in_item.mode            = s_tuser[0];
    in_item.first_of_string = s_tuser[1];
    in_item.start_x         = s_tdata[19:0];
    in_item.start_y         = s_tdata[39:20];
    in_item.char_code       = s_tdata[47:40];
    in_item.text_color      = s_tdata[79:48];
  end

  gdq_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_quad  (out_quad)
  );

  // Pack the result item.
  assign m_tdata = {3'b000, out_quad.quad_color, out_quad.quad_height,
                    out_quad.quad_width, out_quad.quad_y, out_quad.quad_x};
  assign m_tlast = out_quad.last_dot;

endmodule

`default_nettype wire

>>> sv/gdq_cfg.sv
// Configuration register block: dot scale and SD mode behind an APB-style port.
`default_nettype none

module gdq_cfg (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output gdq_pkg::cfg_t     cfg
);
  import gdq_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Register writes; only the word address selects the register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale <= SCALE_RESET;
      cfg.sd    <= 1'b0;
    end else if (wr_en) begin
      case (paddr[2])
        REG_DOT_SCALE: cfg.scale <= pwdata[SCALE_W-1:0];
        REG_SD_MODE:   cfg.sd    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (paddr[2])
      REG_DOT_SCALE: prdata = {{(32-SCALE_W){1'b0}}, cfg.scale};
      REG_SD_MODE:   prdata = {31'b0, cfg.sd};
      default:       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/gdq_addsat.sv
// Shared coordinate adder with saturated view of the sum.
`default_nettype none

module gdq_addsat (
  input  wire logic signed [21:0] a,
  input  wire logic signed [21:0] b,
  output logic signed [21:0]      sum,
  output logic [19:0]             sum_sat
);
  import gdq_pkg::*;

  // Operands stay well inside the 22-bit range, so the sum is exact.
  assign sum     = a + b;
  assign sum_sat = sat20(sum);

endmodule

`default_nettype wire

>>> sv/gdq_engine.sv
// Glyph scan sequencer: setup arithmetic, dot scan through one shared adder, output register.
`default_nettype none

module gdq_engine (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire gdq_pkg::cfg_t    cfg,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire gdq_pkg::in_item_t in_item,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output gdq_pkg::quad_t        out_quad
);
  import gdq_pkg::*;

  state_t state, state_next;

  // Per-item registers.
  logic [COORD_W-1:0]       cursor_x;
  logic [COORD_W-1:0]       line_y;
  logic                     shadow;
  logic [COLOR_W-1:0]       color;
  logic [GLYPH_W-1:0]       bm;
  logic [2:0]               col;
  logic [38:0]              prod;
  logic signed [ACC_W-1:0]  base_x;
  logic signed [ACC_W-1:0]  x_acc;
  logic signed [ACC_W-1:0]  y_acc;

  // Derived quantities.
  logic [17:0]              nine_s;
  logic [15:0]              three_s1;
  logic [17:0]              thirteen_s1;
  logic [HEIGHT_W-1:0]      h_sd;
  logic [HEIGHT_W-1:0]      height;
  logic [HEIGHT_W-1:0]      off;
  logic [ADV_W-1:0]         adv;
  logic signed [ACC_W-1:0]  add_a, add_b, sum;
  logic [COORD_W-1:0]       sum_sat;
  logic                     step_ok;
  logic                     emit;
  logic                     accept;

  // Rounded scale multiples, all half up.
  assign three_s1    = 16'(cfg.scale) * 16'd3 + 16'd1;
  assign thirteen_s1 = 18'(cfg.scale) * 18'd13 + 18'd1;
  assign nine_s      = 18'(cfg.scale) * 18'd9 + 18'd5;
  assign h_sd        = three_s1[15:1];
  assign height      = cfg.sd ? h_sd : HEIGHT_W'(cfg.scale);
  assign adv         = cfg.sd ? thirteen_s1[17:1] : ADV_W'(cfg.scale) * ADV_W'(6);

  // Shadow offset: 1.5*scale in SD mode, 0.9*scale from the reciprocal product otherwise.
  always_comb begin
    if (!shadow) begin
      off = '0;
    end else if (cfg.sd) begin
      off = h_sd;
    end else begin
      off = prod[38:DIV10_SHIFT];
    end
  end

  gdq_addsat u_add (
    .a       (add_a),
    .b       (add_b),
    .sum     (sum),
    .sum_sat (sum_sat)
  );

  assign accept  = in_valid & in_ready;
  assign step_ok = ~bm[GLYPH_W-1] | ~out_valid | out_ready;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, adder operand selection and handshake.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    emit       = 1'b0;
    add_a      = x_acc;
    add_b      = ACC_W'(cfg.scale);
    case (state)
      ST_IDLE: begin
        // No item is taken while the block is held in reset.
        in_ready = ~rst;
        if (in_valid) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_next = ST_BASE_X;
      end
      ST_BASE_X: begin
        add_a      = {{(ACC_W-COORD_W){cursor_x[COORD_W-1]}}, cursor_x};
        add_b      = ACC_W'(off);
        state_next = ST_BASE_Y;
      end
      ST_BASE_Y: begin
        add_a      = {{(ACC_W-COORD_W){line_y[COORD_W-1]}}, line_y};
        add_b      = ACC_W'(off);
        state_next = (bm == '0) ? ST_ADV : ST_SCAN;
      end
      ST_SCAN: begin
        add_a = (col == 3'd4) ? y_acc : x_acc;
        if (step_ok) begin
          emit = bm[GLYPH_W-1];
          if (bm[GLYPH_W-2:0] == '0) begin
            state_next = ST_ADV;
          end
        end
      end
      ST_ADV: begin
        add_a      = {{(ACC_W-COORD_W){cursor_x[COORD_W-1]}}, cursor_x};
        add_b      = ACC_W'(adv);
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Cursor and line position.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= '0;
      line_y   <= '0;
    end else if (accept && in_item.first_of_string) begin
      cursor_x <= in_item.start_x;
      line_y   <= in_item.start_y;
    end else if (state == ST_ADV) begin
      cursor_x <= sum_sat;
    end
  end

  // Item datapath: latch on accept, setup, then one dot position per step.
  always_ff @(posedge clk) begin
    if (accept) begin
      shadow <= in_item.mode;
      color  <= in_item.mode ? (cfg.sd ? SHADOW_COLOR_SD : SHADOW_COLOR_HD)
                             : in_item.text_color;
      bm     <= glyph_bits(in_item.char_code);
      col    <= '0;
    end
    if (state == ST_LOAD) begin
      prod <= 39'(nine_s) * 39'(DIV10_MUL);
    end
    if (state == ST_BASE_X) begin
      base_x <= sum;
      x_acc  <= sum;
    end
    if (state == ST_BASE_Y) begin
      y_acc <= sum;
    end
    if (state == ST_SCAN && step_ok) begin
      bm <= {bm[GLYPH_W-2:0], 1'b0};
      if (col == 3'd4) begin
        col   <= '0;
        x_acc <= base_x;
        y_acc <= sum;
      end else begin
        col   <= col + 3'd1;
        x_acc <= sum;
      end
    end
  end

  // Output register: holds a quad until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_quad.quad_x      <= sat20(x_acc);
      out_quad.quad_y      <= sat20(y_acc);
      out_quad.quad_width  <= cfg.scale;
      out_quad.quad_height <= height;
      out_quad.quad_color  <= color;
      out_quad.last_dot    <= (bm[GLYPH_W-2:0] == '0);
    end
  end

endmodule

`default_nettype wire
